>>> sv/gte_pkg.sv
// gte_pkg: shared types and constants for the greedy token encoder unit
// no dependencies
package gte_pkg;

  typedef enum logic [2:0] {
    FN_OFFSET = 3'd0,
    FN_BSTART = 3'd1,
    FN_BINDEX = 3'd2,
    FN_TBYTE  = 3'd3,
    FN_BEGIN  = 3'd4,
    FN_DATA   = 3'd5,
    FN_END    = 3'd6,
    FN_NONE   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    CFG_COUNT = 3'd0,
    CFG_LEN   = 3'd1,
    CFG_BOS   = 3'd2,
    CFG_TEXT  = 3'd3,
    CFG_EOS   = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BOS, S_TEXT, S_EOS, S_FIND0, S_FIND1, S_FIND2, S_IDX0, S_IDX1,
    S_OFS0, S_OFS1, S_OFS2, S_CHECK, S_CMP0, S_CMP1, S_CONSUME, S_EMIT, S_ERR
  } state_t;

  localparam logic [12:0] ID_BOS  = 13'd1;
  localparam logic [12:0] ID_EOS  = 13'd2;
  localparam logic [12:0] ID_TEXT = 13'd3;

endpackage

>>> sv/greedy_token_encoder_unit.sv
// greedy_token_encoder_unit: top level of the greedy longest-match byte tokenizer
// depends on gte_pkg; holds the token tables as synchronous memories
//
// usage: token tables are loaded with requests on s_axis (func 0..3), then text is
// sent as a begin request, data byte requests and an end request. results leave
// on m_axis, tlast marks the final result of a request, tuser carries the status
// (1 means an invalid table entry, with token id 0).
// configuration registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// one request is handled at a time. loads and data bytes that do not fill the
// window are accepted one a cycle while no result waits in the output register.
// a match step reads the bucket bounds, then per candidate its index and offsets,
// compares it byte by byte and moves to the next candidate when it misses; the
// window then shifts once per consumed byte and the token is put in the output
// register. each table memory has a single read port.
// reset clears the window, the fill count, the registers and the control state;
// table memories are undefined until loaded. when m_axis_tready is low the
// result stays in the output register and the engine waits before its next result.
module greedy_token_encoder_unit #(
  parameter int MAX_LEARNED       = 4096,
  parameter int TOKEN_STORE_BYTES = 65536,
  parameter int WINDOW_BYTES      = 16,
  parameter int BYTE_ID_BASE      = 4,
  parameter int LEARNED_ID_BASE   = 260
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: func[2:0], load_address[18:3], load_value[35:19], data_byte[43:36]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: emitted id[12:0]
  output logic [15:0] m_axis_tdata,
  // tuser: status
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import gte_pkg::*;

  localparam int LW = (MAX_LEARNED > 1) ? $clog2(MAX_LEARNED) : 1;
  localparam int OW = $clog2(MAX_LEARNED + 1);
  localparam int TW = $clog2(TOKEN_STORE_BYTES);
  localparam int WW = $clog2(WINDOW_BYTES);
  localparam int FW = $clog2(WINDOW_BYTES + 1);

  // configuration
  logic [12:0] learned_token_count;
  logic [16:0] token_data_length;
  logic add_begin_marker, add_text_marker, add_end_marker;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      learned_token_count <= '0;
      token_data_length   <= '0;
      add_begin_marker    <= 1'b0;
      add_text_marker     <= 1'b0;
      add_end_marker      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNT: learned_token_count <= cfg_data[12:0];
        CFG_LEN:   token_data_length   <= cfg_data;
        CFG_BOS:   add_begin_marker    <= cfg_data[0];
        CFG_TEXT:  add_text_marker     <= cfg_data[0];
        CFG_EOS:   add_end_marker      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [2:0]  in_func;
  logic [15:0] in_addr;
  logic [16:0] in_val;
  logic [7:0]  in_byte;
  assign in_func = s_axis_tdata[2:0];
  assign in_addr = s_axis_tdata[18:3];
  assign in_val  = s_axis_tdata[35:19];
  assign in_byte = s_axis_tdata[43:36];

  // table memories
  logic [16:0] offset_mem [MAX_LEARNED+1];
  logic [12:0] bstart_mem [257];
  logic [LW-1:0] bindex_mem [MAX_LEARNED];
  logic [7:0]  tbyte_mem  [TOKEN_STORE_BYTES];

  logic [16:0] ofs_rd;
  logic [12:0] bs_rd;
  logic [LW-1:0] bi_rd;
  logic [7:0]  tb_rd;
  logic [OW-1:0] ofs_ra;
  logic [8:0]  bs_ra;
  logic [LW-1:0] bi_ra;
  logic [TW-1:0] tb_ra;

  logic in_req;
  assign in_req = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (in_req && in_func == FN_OFFSET && 32'(in_addr) < MAX_LEARNED + 1)
      offset_mem[OW'(in_addr)] <= in_val;
    ofs_rd <= offset_mem[ofs_ra];
  end
  always_ff @(posedge clk) begin
    if (in_req && in_func == FN_BSTART && in_addr < 16'd257)
      bstart_mem[in_addr[8:0]] <= in_val[12:0];
    bs_rd <= bstart_mem[bs_ra];
  end
  always_ff @(posedge clk) begin
    if (in_req && in_func == FN_BINDEX && 32'(in_addr) < MAX_LEARNED)
      bindex_mem[in_addr[LW-1:0]] <= LW'(in_val);
    bi_rd <= bindex_mem[bi_ra];
  end
  always_ff @(posedge clk) begin
    if (in_req && in_func == FN_TBYTE && 32'(in_addr) < TOKEN_STORE_BYTES)
      tbyte_mem[TW'(in_addr)] <= in_val[7:0];
    tb_rd <= tbyte_mem[tb_ra];
  end

  // engine state
  state_t state, state_next;
  logic [7:0] win [WINDOW_BYTES];
  logic [FW-1:0] fill;
  logic streaming;               // data byte step vs end flush
  logic [12:0] pos, stop;
  logic [LW-1:0] idx;
  logic [16:0] ofs_a, ofs_b;
  logic [16:0] sz;
  logic [FW-1:0] cmp_k;           // byte being compared
  logic [FW-1:0] mlen;            // bytes to consume
  logic [FW-1:0] shift_k;
  logic [12:0] tok_id;
  logic [12:0] out_id;
  logic out_st, out_last, out_v;

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {3'b0, out_id};
  assign m_axis_tuser  = out_st;
  assign m_axis_tlast  = out_last;
  assign s_axis_tready = (state == S_IDLE) && !out_v;

  logic [WW-1:0] cmp_i;
  assign cmp_i = cmp_k[WW-1:0];

  // read addresses
  always_comb begin
    bs_ra  = (state == S_FIND0) ? {1'b0, win[0]} : 9'(win[0]) + 9'd1;
    bi_ra  = pos[LW-1:0];
    ofs_ra = (state == S_IDX1) ? OW'(bi_rd) : OW'(idx) + OW'(1);
    tb_ra  = TW'(ofs_a + 17'(cmp_k));
  end

  logic bad_idx, bad_ofs;
  always_comb begin
    bad_idx = (32'(bi_rd) >= 32'(learned_token_count)) || (32'(bi_rd) >= MAX_LEARNED);
    bad_ofs = (ofs_rd <= ofs_a) || (ofs_rd > token_data_length) ||
              (32'(ofs_rd) > TOKEN_STORE_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      out_v <= 1'b0;
      for (int i = 0; i < WINDOW_BYTES; i++) win[i] <= '0;
    end else begin
      state <= state_next;
      if (out_v && m_axis_tready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (in_req) begin
          streaming <= (in_func == FN_DATA);
          if (in_func == FN_BEGIN) begin
            fill <= '0;
            for (int i = 0; i < WINDOW_BYTES; i++) win[i] <= '0;
          end
          if (in_func == FN_DATA && 32'(fill) < WINDOW_BYTES) begin
            win[fill[WW-1:0]] <= in_byte;
            fill <= fill + FW'(1);
          end
        end
        S_BOS: if (!out_v) begin
          out_v <= 1'b1; out_id <= ID_BOS; out_st <= 1'b0; out_last <= !add_text_marker;
        end
        S_TEXT: if (!out_v) begin
          out_v <= 1'b1; out_id <= ID_TEXT; out_st <= 1'b0; out_last <= 1'b1;
        end
        S_EOS: if (!out_v) begin
          out_v <= 1'b1; out_id <= ID_EOS; out_st <= 1'b0; out_last <= 1'b1;
        end
        S_FIND0: begin
          tok_id <= 13'(BYTE_ID_BASE) + 13'(win[0]);
          mlen   <= FW'(1);
        end
        S_FIND1: pos <= bs_rd;
        S_FIND2: stop <= bs_rd;
        S_IDX1: idx <= bi_rd;
        S_OFS0: ofs_a <= ofs_rd;
        S_OFS2: begin
          ofs_b <= ofs_rd;
          sz    <= ofs_rd - ofs_a;
          cmp_k <= '0;
        end
        S_CMP1: cmp_k <= cmp_k + FW'(1);
        S_CHECK: if (pos + 13'd1 < stop) pos <= pos + 13'd1;
        S_CONSUME: begin
          if (shift_k == '0) begin
            if (mlen > fill) mlen <= fill;
          end
          for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] <= win[i+1];
          win[WINDOW_BYTES-1] <= '0;
          if (fill != '0) fill <= fill - FW'(1);
        end
        S_EMIT: if (!out_v) begin
          out_v <= 1'b1; out_id <= tok_id; out_st <= 1'b0;
          out_last <= streaming || (fill == '0 && !add_end_marker);
        end
        S_ERR: if (!out_v) begin
          out_v <= 1'b1; out_id <= '0; out_st <= 1'b1; out_last <= 1'b1;
          fill <= '0;
          for (int i = 0; i < WINDOW_BYTES; i++) win[i] <= '0;
        end
        default: ;
      endcase
      // a match sets the id and length when the compare finishes
      if (state == S_CMP1 && 32'(cmp_k) + 1 >= 32'(sz) && tb_rd == win[cmp_i]) begin
        tok_id <= 13'(LEARNED_ID_BASE) + 13'(idx);
        mlen   <= FW'(sz);
      end
      if (state == S_OFS2 || state == S_IDLE) shift_k <= '0;
      else if (state == S_CONSUME) shift_k <= shift_k + FW'(1);
    end
  end

  logic cmp_done, cmp_hit;
  always_comb begin
    cmp_hit  = (tb_rd == win[cmp_i]);
    cmp_done = 32'(cmp_k) + 1 >= 32'(sz);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_req) begin
        case (in_func)
          FN_BEGIN: state_next = add_begin_marker ? S_BOS :
                                 (add_text_marker ? S_TEXT : S_IDLE);
          FN_DATA: if (32'(fill) + ((32'(fill) < WINDOW_BYTES) ? 1 : 0) >= WINDOW_BYTES)
            state_next = S_FIND0;
          FN_END: state_next = (fill != '0) ? S_FIND0 :
                               (add_end_marker ? S_EOS : S_IDLE);
          default: ;
        endcase
      end
      S_BOS:  if (!out_v) state_next = add_text_marker ? S_TEXT : S_IDLE;
      S_TEXT: if (!out_v) state_next = S_IDLE;
      S_EOS:  if (!out_v) state_next = S_IDLE;
      S_FIND0: state_next = S_FIND1;
      S_FIND1: state_next = S_FIND2;
      S_FIND2: state_next = (pos < bs_rd) ? S_IDX0 : S_CONSUME;
      S_IDX0: state_next = (32'(pos) >= MAX_LEARNED) ? S_ERR : S_IDX1;
      S_IDX1: state_next = bad_idx ? S_ERR : S_OFS0;
      S_OFS0: state_next = S_OFS1;
      S_OFS1: state_next = S_OFS2;
      S_OFS2: begin
        if (bad_ofs) state_next = S_ERR;
        else if (streaming && 32'(ofs_rd - ofs_a) > WINDOW_BYTES) state_next = S_ERR;
        else if (32'(ofs_rd - ofs_a) <= 32'(fill)) state_next = S_CMP0;
        else state_next = S_CHECK;
      end
      S_CMP0: state_next = S_CMP1;
      S_CMP1: begin
        if (!cmp_hit) state_next = S_CHECK;
        else if (cmp_done) state_next = S_CONSUME;
        else state_next = S_CMP0;
      end
      S_CHECK: state_next = (pos + 13'd1 < stop) ? S_IDX0 : S_CONSUME;
      S_CONSUME: begin
        if (shift_k + FW'(1) >= ((mlen > fill && shift_k == '0) ? fill : mlen))
          state_next = S_EMIT;
      end
      S_EMIT: if (!out_v) begin
        if (streaming) state_next = S_IDLE;
        else if (fill != '0) state_next = S_FIND0;
        else state_next = add_end_marker ? S_EOS : S_IDLE;
      end
      S_ERR: if (!out_v) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic unused_ok;
  assign unused_ok = ^{ofs_b, s_axis_tdata[47:44]};

endmodule

>>> dv/greedy_token_encoder_unit_tb.sv
// greedy_token_encoder_unit_tb: self-checking bench for the greedy token encoder unit
// depends on gte_pkg and greedy_token_encoder_unit; loads token tables, streams text
// and checks every emitted token against an internal tokenizer predictor
module greedy_token_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gte_pkg::*;

  localparam int MAX_TOK    = 4096;
  localparam int STORE_B    = 65536;
  localparam int WIN_B      = 16;
  localparam int RAW_BASE   = 4;
  localparam int LRN_BASE   = 260;
  localparam int STALL_LIM  = 20000;  // cycles with no handshake anywhere
  localparam int SETTLE_CYC = 600;    // worst match step plus window shift, with margin
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  always #1 clk = ~clk;

  greedy_token_encoder_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [12:0] id;
    logic        st;
    logic        last;
  } token_out_t;

  // directed stimulus row; typed rows carry their single expected token id
  typedef struct {
    func_t       f;
    logic [15:0] a;
    logic [16:0] v;
    logic [7:0]  b;
    bit          typed;
    logic [12:0] tid;
  } dir_row_t;

  token_out_t pending_tokens[$];
  int mismatches = 0;
  int s_idle_pct = 0;
  int r_idle_pct = 0;
  bit rx_hold = 1'b0;
  int quiet_cycles = 0;
  int table_len = 0;

  // predictor copy of the tables, window and registers
  logic [16:0] tk_offs   [0:MAX_TOK];
  logic [12:0] tk_bstart [0:256];
  logic [11:0] tk_bidx   [0:MAX_TOK-1];
  logic [7:0]  tk_bytes  [0:STORE_B-1];
  logic [7:0]  tk_win    [0:WIN_B-1];
  int          tk_fill = 0;
  int          r_count = 0, r_len = 0;
  bit          r_bos = 0, r_text = 0, r_eos = 0;

  function automatic void clear_window();
    for (int i = 0; i < WIN_B; i++) tk_win[i] = 8'h00;
    tk_fill = 0;
  endfunction

  function automatic void expect_token(logic [12:0] id, logic st);
    token_out_t t;
    t.id = id;
    t.st = st;
    t.last = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  // greedy match at the window head; returns 1 on a bad table entry
  function automatic bit encode_head(input bit streaming, output int id);
    int head, pos, stop, idx, a, b, sz, ln;
    bit hit;
    head = int'(tk_win[0]);
    pos = int'(tk_bstart[head]);
    stop = int'(tk_bstart[head+1]);
    id = RAW_BASE + head;
    ln = 1;
    for (; pos < stop; pos++) begin
      if (pos >= MAX_TOK) return 1'b1;
      idx = int'(tk_bidx[pos]);
      if (idx >= r_count || idx >= MAX_TOK) return 1'b1;
      a = int'(tk_offs[idx]);
      b = int'(tk_offs[idx+1]);
      if (b <= a || b > r_len || b > STORE_B) return 1'b1;
      sz = b - a;
      if (streaming && sz > WIN_B) return 1'b1;
      if (sz <= tk_fill) begin
        hit = 1'b1;
        for (int k = 0; k < sz; k++) if (tk_win[k] != tk_bytes[a+k]) hit = 1'b0;
        if (hit) begin
          id = LRN_BASE + idx;
          ln = sz;
          break;
        end
      end
    end
    if (ln > tk_fill) ln = tk_fill;
    for (int k = 0; k < WIN_B; k++) tk_win[k] = (k + ln < tk_fill) ? tk_win[k+ln] : 8'h00;
    tk_fill -= ln;
    return 1'b0;
  endfunction

  // predicted tokens of one accepted request
  function automatic void tokenize_request(func_t f, logic [15:0] a, logic [16:0] v,
                                           logic [7:0] b);
    int n0, id;
    bit bad;
    token_out_t t;
    n0 = pending_tokens.size();
    bad = 1'b0;
    case (f)
      FN_OFFSET: if (a < MAX_TOK + 1) tk_offs[a] = v;
      FN_BSTART: if (a < 257) tk_bstart[a] = v[12:0];
      FN_BINDEX: if (a < MAX_TOK) tk_bidx[a] = v[11:0];
      FN_TBYTE:  tk_bytes[a] = v[7:0];
      FN_BEGIN: begin
        clear_window();
        if (r_bos) expect_token(ID_BOS, 1'b0);
        if (r_text) expect_token(ID_TEXT, 1'b0);
      end
      FN_DATA: begin
        if (tk_fill < WIN_B) begin
          tk_win[tk_fill] = b;
          tk_fill++;
        end
        if (tk_fill >= WIN_B) begin
          if (encode_head(1'b1, id)) begin
            clear_window();
            expect_token(13'd0, 1'b1);
          end else expect_token(id[12:0], 1'b0);
        end
      end
      FN_END: begin
        while (tk_fill > 0 && !bad) begin
          if (encode_head(1'b0, id)) begin
            clear_window();
            expect_token(13'd0, 1'b1);
            bad = 1'b1;
          end else expect_token(id[12:0], 1'b0);
        end
        if (!bad && r_eos) expect_token(ID_EOS, 1'b0);
      end
      default: ;
    endcase
    if (pending_tokens.size() > n0) begin
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  // one request on the input stream, followed by a random gap
  task automatic send_request(func_t f, logic [15:0] a, logic [16:0] v, logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, b, v, a, f};
    do @(posedge clk); while (!s_axis_tready);
    tokenize_request(f, a, v, b);
    while ($urandom_range(99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [16:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COUNT: r_count = int'(d[12:0]);
      CFG_LEN:   r_len = int'(d);
      CFG_BOS:   r_bos = d[0];
      CFG_TEXT:  r_text = d[0];
      CFG_EOS:   r_eos = d[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int cnt, int len, bit bos, bit text, bit eos);
    s_axis_tvalid <= 1'b0;
    write_reg(CFG_COUNT, 17'(cnt));
    write_reg(CFG_LEN, 17'(len));
    write_reg(CFG_BOS, 17'(bos));
    write_reg(CFG_TEXT, 17'(text));
    write_reg(CFG_EOS, 17'(eos));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // idle point for register writes: loads and partial windows give no token
  task automatic settle();
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // long receiver hold-off, counted here while the sender keeps going
  task automatic hold_receiver(int n);
    rx_hold = 1'b1;
    repeat (n) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  // builds and loads a token table over the letters a..c; every entry that a
  // match can read is written, bucket bounds only for bytes that text carries.
  // a faulty table adds a zero-length token, a token longer than the window,
  // an index past the learned count in bucket b and a bucket at or past the
  // table end for byte 0
  task automatic build_tables(int nt, bit faulty);
    int offl[0:40];
    logic [7:0] tb[0:511];
    logic [11:0] bl[0:63];
    int bs[0:256];
    int keys[8];
    int pos, sz;
    keys = '{0, 1, int'(CH_A), int'(CH_B), int'(CH_C), int'(CH_C) + 1, 255, 256};
    offl[0] = 0;
    for (int k = 0; k < nt; k++) begin
      if (k == 0) sz = WIN_B;
      else if (faulty && k == 1) sz = WIN_B + 4;
      else if (faulty && k == 2) sz = 0;
      else sz = $urandom_range(1, 3);
      offl[k+1] = offl[k] + sz;
    end
    table_len = offl[nt];
    for (int i = 0; i < table_len; i++) tb[i] = CH_A + 8'($urandom_range(0, 2));
    pos = 0;
    for (int h = 0; h < 256; h++) begin
      bs[h] = pos;
      // longest candidates first
      for (int ln = WIN_B + 4; ln >= 0; ln--)
        for (int k = 0; k < nt; k++) begin
          sz = offl[k+1] - offl[k];
          if (sz == ln && ((sz > 0 && tb[offl[k]] == h) || (sz == 0 && h == CH_A))) begin
            bl[pos] = 12'(k);
            pos++;
          end
        end
      if (faulty && h == CH_B) begin
        bl[pos] = 12'(nt);
        pos++;
      end
    end
    bs[256] = pos;
    if (faulty) begin
      bs[0] = MAX_TOK;
      bs[1] = MAX_TOK + 1;
    end
    for (int k = 0; k <= nt; k++)
      send_request(FN_OFFSET, 16'(k), 17'(offl[k]), 8'($urandom_range(255)));
    for (int i = 0; i < table_len; i++)
      send_request(FN_TBYTE, 16'(i), 17'(tb[i]), 8'($urandom_range(255)));
    for (int i = 0; i < pos; i++)
      send_request(FN_BINDEX, 16'(i), 17'(bl[i]), 8'($urandom_range(255)));
    foreach (keys[j])
      send_request(FN_BSTART, 16'(keys[j]), 17'(bs[keys[j]]), 8'($urandom_range(255)));
  endtask

  // text bytes: mostly letters, with both byte extremes
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hFF;
    return CH_A + 8'($urandom_range(0, 2));
  endfunction

  // mostly begin / text / end runs, with out-of-range or unused-area loads, unused codes and broken runs
  task automatic random_text(int n);
    int sent, len, r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 4) send_request(FN_NONE, 16'($urandom), 17'($urandom), 8'($urandom));
      else if (r < 6) send_request(FN_OFFSET, 16'($urandom_range(MAX_TOK + 1, 65535)),
                                   17'($urandom), 8'($urandom));
      else if (r < 8) send_request(FN_BSTART, 16'($urandom_range(257, 65535)),
                                   17'($urandom), 8'($urandom));
      else if (r < 10) send_request(FN_BINDEX, 16'($urandom_range(MAX_TOK, 65535)),
                                    17'($urandom), 8'($urandom));
      else if (r < 12) send_request(FN_TBYTE, 16'($urandom_range(1024, 65535)),
                                    17'($urandom), 8'($urandom));
      else begin
        send_request(FN_BEGIN, 16'($urandom), 17'($urandom), 8'($urandom));
        sent++;
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
          send_request(FN_DATA, 16'($urandom), 17'($urandom), text_byte());
          sent++;
        end
        // some runs are left open and cut by the next begin
        if ($urandom_range(9) != 0) begin
          send_request(FN_END, 16'($urandom), 17'($urandom), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  // result side: compare against the oldest expected token, then pick readiness
  always @(posedge clk) begin
    token_out_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: id=%0d status=%0b last=%0b",
                   m_axis_tdata[12:0], m_axis_tuser, m_axis_tlast);
      end else begin
        e = pending_tokens.pop_front();
        if (m_axis_tdata[12:0] !== e.id || m_axis_tuser !== e.st || m_axis_tlast !== e.last)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: expected id=%0d status=%0b last=%0b, %s%0d %s%0b %s%0b",
                     e.id, e.st, e.last, "got id=", m_axis_tdata[12:0],
                     "status=", m_axis_tuser, "last=", m_axis_tlast);
        end
      end
    end
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= r_idle_pct);
  end

  // watchdog on stretches with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIM) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    build_tables(6, 1'b0);
    set_regs(6, table_len, 1'b1, 1'b0, 1'b1);

    // directed: markers, byte extremes, window fill and flush, ignored and unused-area requests
    rows.push_back('{FN_BEGIN, 16'hFFFF, 17'h1FFFF, 8'hFF, 1'b1, ID_BOS});
    rows.push_back('{FN_DATA, 16'h0000, 17'h00000, 8'h00, 1'b0, 13'd0});
    rows.push_back('{FN_DATA, 16'h0000, 17'h00000, 8'hFF, 1'b0, 13'd0});
    for (int i = 0; i < 13; i++) rows.push_back('{FN_DATA, 16'h0, 17'h0, CH_A, 1'b0, 13'd0});
    rows.push_back('{FN_DATA, 16'h0, 17'h0, CH_B, 1'b0, 13'd0});
    rows.push_back('{FN_END, 16'h0, 17'h0, 8'h00, 1'b0, 13'd0});
    rows.push_back('{FN_END, 16'h0, 17'h0, 8'h00, 1'b1, ID_EOS});
    rows.push_back('{FN_NONE, 16'hFFFF, 17'h1FFFF, 8'hFF, 1'b0, 13'd0});
    rows.push_back('{FN_OFFSET, 16'd4097, 17'h10000, 8'h00, 1'b0, 13'd0});
    rows.push_back('{FN_BSTART, 16'd257, 17'h1FFFF, 8'h00, 1'b0, 13'd0});
    rows.push_back('{FN_BINDEX, 16'd4096, 17'h00FFF, 8'h00, 1'b0, 13'd0});
    rows.push_back('{FN_TBYTE, 16'hFFFF, 17'h10000, 8'h00, 1'b0, 13'd0});
    rows.push_back('{FN_BEGIN, 16'h0, 17'h0, 8'h00, 1'b1, ID_BOS});
    foreach (rows[i]) begin
      token_out_t t;
      row = rows[i];
      send_request(row.f, row.a, row.v, row.b);
      if (row.typed) begin
        t = pending_tokens.pop_back();
        t.id = row.tid;
        t.st = 1'b0;
        pending_tokens.push_back(t);
      end
    end
    random_text(12);

    // sender idles often, all markers on
    settle();
    s_idle_pct = 74;
    set_regs(6, table_len, 1'b1, 1'b1, 1'b1);
    random_text(18);

    // receiver stalls often, register maxima, markers off
    settle();
    s_idle_pct = 0;
    r_idle_pct = 74;
    set_regs(MAX_TOK, STORE_B, 1'b0, 1'b0, 1'b0);
    random_text(18);

    // no learned tokens and no token data: every candidate is a bad entry
    settle();
    s_idle_pct = 6;
    r_idle_pct = 6;
    set_regs(0, 0, 1'b1, 1'b1, 1'b0);
    random_text(18);

    // faulty table, long receiver hold-off while requests keep coming
    settle();
    s_idle_pct = 0;
    r_idle_pct = 0;
    build_tables(6, 1'b1);
    set_regs(6, table_len, 1'b0, 1'b1, 1'b1);
    fork
      hold_receiver(500);
    join_none
    random_text(18);

    // clean table with short token data length, sender pause halfway
    settle();
    build_tables(8, 1'b0);
    set_regs(8, table_len - 2, 1'b1, 1'b1, 1'b1);
    random_text(8);
    drain();
    random_text(8);

    settle();
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/gte_pkg.sv
sv/greedy_token_encoder_unit.sv
dv/greedy_token_encoder_unit_tb.sv
